### rtl/core/bcbs_pkg.sv
package bcbs_pkg;

    // sample format of the correlation stream (Q1.15 at 16 bits)
    localparam int SAMPLE_BITS = 16;
    localparam int SLIP_LIMIT_DEF = 10;

    // register widths
    localparam int TICKS_W = 13;
    localparam int THRESH_W = 15;
    localparam int AVGW_W = 9;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W = 2;
    localparam int SKIP_W = 12;
    localparam int PRELOAD_W = 13;
    localparam int INDEX_W = 32;

    // signed width that holds a sample difference and the threshold
    localparam int CMP_W = ((SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W) + 2;
    // signed width used for skip and preload arithmetic
    localparam int CNT_W = 16;

    // register reset values
    localparam logic [TICKS_W-1:0] TICKS_RST = TICKS_W'(100);
    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(6554);
    localparam logic [AVGW_W-1:0] AVGW_RST = AVGW_W'(10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW = 2'd2;

    typedef struct packed {
        logic                          first;
        logic signed [SAMPLE_BITS-1:0] corr_sample;
    } t_in_item;

    typedef struct packed {
        logic               bit_value;
        logic               end_of_stream;
        logic [INDEX_W-1:0] bit_index;
    } t_out_item;

    // skip reload: block_ticks - 3 + delta, clamped to 0..4095
    function automatic logic [SKIP_W-1:0] skip_base(
        input logic [TICKS_W-1:0] ticks,
        input logic signed [1:0]  delta
    );
        logic signed [CNT_W-1:0] s;
        s = $signed({{(CNT_W-TICKS_W){1'b0}}, ticks}) - CNT_W'(3)
            + CNT_W'(delta);
        if (s < 0) begin
            skip_base = '0;
        end else if (s > CNT_W'(4095)) begin
            skip_base = {SKIP_W{1'b1}};
        end else begin
            skip_base = s[SKIP_W-1:0];
        end
    endfunction

    // preload: block_ticks + avg_window/2 - 1, clamped to 0..8191
    function automatic logic [PRELOAD_W-1:0] preload_len(
        input logic [TICKS_W-1:0] ticks,
        input logic [AVGW_W-1:0]  avgw
    );
        logic signed [CNT_W-1:0] p;
        p = $signed({{(CNT_W-TICKS_W){1'b0}}, ticks})
            + $signed({{(CNT_W-AVGW_W+1){1'b0}}, avgw[AVGW_W-1:1]}) - CNT_W'(1);
        if (p < 0) begin
            preload_len = '0;
        end else if (p > CNT_W'(8191)) begin
            preload_len = {PRELOAD_W{1'b1}};
        end else begin
            preload_len = p[PRELOAD_W-1:0];
        end
    endfunction

endpackage

### rtl/core/block_correlation_bit_slicer.sv
// Bit slicer for a block self-correlation stream. Each input transaction
// carries one averaged correlation sample (signed Q1.15). A transaction with
// first set restarts the stream: the block drops a preload of
// block_ticks + avg_window/2 - 1 samples, then repeatedly skips
// block_ticks - 3 samples and gathers an early, center and late sample. On
// the late sample one result transaction is produced: the center sample is
// sliced against the threshold and the previous level into a bit, and side
// peak dominance nudges the sample timing by one once the net vote count
// passes SLIP_LIMIT.
// An undecidable center gives a result with end_of_stream set, after which
// samples are dropped until the next first. Every sample is handled in the
// cycle it is accepted, by one pass of compare logic into the state and
// output registers, so one transaction is taken per clock; the output
// register stalls the input only while a result waits and i_out_ready is low.
// Configuration writes are taken at any time and should be made while idle.
module block_correlation_bit_slicer
    import bcbs_pkg::*;
#(
    parameter int SLIP_LIMIT = SLIP_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLIP_W = $clog2(SLIP_LIMIT + 2) + 1;
    localparam logic signed [SLIP_W-1:0] SLIP_HI = SLIP_W'(SLIP_LIMIT);
    localparam logic signed [SLIP_W-1:0] SLIP_LO = -SLIP_HI;

    // configuration registers
    logic [TICKS_W-1:0]  r_block_ticks;
    logic [THRESH_W-1:0] r_threshold;
    logic [AVGW_W-1:0]   r_avg_window;

    // stream state
    logic                          r_ended, n_ended;
    logic [PRELOAD_W-1:0]          r_preload, n_preload;
    logic [SKIP_W-1:0]             r_skip, n_skip;
    logic [1:0]                    r_fill, n_fill;
    logic signed [SAMPLE_BITS-1:0] r_early, n_early;
    logic signed [SAMPLE_BITS-1:0] r_center, n_center;
    logic signed [SLIP_W-1:0]      r_slip, n_slip;
    logic signed [SAMPLE_BITS-1:0] r_level, n_level;
    logic [INDEX_W-1:0]            r_bits, n_bits;

    // output register
    logic      r_out_valid;
    t_out_item r_out, n_out;
    logic      n_fire;

    logic in_acc;

    // step signals
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [CMP_W-1:0]       cx, cr, cl, cth;
    logic [SAMPLE_BITS:0]          a0, a1, a2;
    logic                          opp_ec, opp_cl;
    logic signed [1:0]             delta;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign x = i_in_data.corr_sample;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_ticks <= TICKS_RST;
            r_threshold   <= THRESH_RST;
            r_avg_window  <= AVGW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_TICKS: r_block_ticks <= i_cfg_data[TICKS_W-1:0];
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THRESH_W-1:0];
                CFG_AVG_WINDOW:  r_avg_window  <= i_cfg_data[AVGW_W-1:0];
                default: ;
            endcase
        end
    end

    // per-sample step
    always_comb begin
        n_ended   = r_ended;
        n_preload = r_preload;
        n_skip    = r_skip;
        n_fill    = r_fill;
        n_early   = r_early;
        n_center  = r_center;
        n_slip    = r_slip;
        n_level   = r_level;
        n_bits    = r_bits;
        n_fire    = 1'b0;
        n_out     = r_out;
        delta     = 2'sd0;
        cx        = '0;
        cr        = '0;
        cl        = '0;
        cth       = '0;
        a0        = '0;
        a1        = '0;
        a2        = '0;
        opp_ec    = 1'b0;
        opp_cl    = 1'b0;

        if (in_acc) begin
            // restart before this sample
            if (i_in_data.first) begin
                n_ended   = 1'b0;
                n_preload = preload_len(r_block_ticks, r_avg_window);
                n_skip    = skip_base(r_block_ticks, 2'sd0);
                n_fill    = 2'd0;
                n_early   = '0;
                n_center  = '0;
                n_slip    = '0;
                n_level   = '0;
                n_bits    = '0;
            end

            if (n_ended) begin
                // stream inactive, drop sample
            end else if (n_preload != '0) begin
                n_preload = n_preload - PRELOAD_W'(1);
            end else if (n_skip != '0) begin
                n_skip = n_skip - SKIP_W'(1);
            end else if (n_fill == 2'd0) begin
                n_early = x;
                n_fill  = 2'd1;
            end else if (n_fill == 2'd1) begin
                n_center = x;
                n_fill   = 2'd2;
            end else begin
                // late sample: timing vote
                n_fill = 2'd0;
                opp_ec = (n_early < 0 && n_center > 0) || (n_early > 0 && n_center < 0);
                opp_cl = (n_center < 0 && x > 0) || (n_center > 0 && x < 0);
                a0 = n_early[SAMPLE_BITS-1] ? -{n_early[SAMPLE_BITS-1], n_early}
                                            : {1'b0, n_early};
                a1 = n_center[SAMPLE_BITS-1] ? -{n_center[SAMPLE_BITS-1], n_center}
                                             : {1'b0, n_center};
                a2 = x[SAMPLE_BITS-1] ? -{x[SAMPLE_BITS-1], x} : {1'b0, x};
                if (!opp_ec && !opp_cl) begin
                    if (a1 > a0 && a1 > a2) begin
                        // on time
                    end else if (a0 > a2) begin
                        n_slip = n_slip - SLIP_W'(1);
                    end else if (a0 < a2) begin
                        n_slip = n_slip + SLIP_W'(1);
                    end
                    if (n_slip > SLIP_HI) begin
                        n_slip = '0;
                        delta  = 2'sd1;
                    end else if (n_slip < SLIP_LO) begin
                        n_slip = '0;
                        delta  = -2'sd1;
                    end
                end
                n_skip = skip_base(r_block_ticks, delta);

                // slice the center sample
                cr  = CMP_W'(n_center);
                cl  = CMP_W'(n_level);
                cth = $signed({{(CMP_W-THRESH_W){1'b0}}, r_threshold});
                cx  = cl - cr;
                n_fire              = 1'b1;
                n_out.bit_index     = n_bits;
                n_out.end_of_stream = 1'b0;
                n_out.bit_value     = 1'b0;
                if (cr > cth) begin
                    n_out.bit_value = 1'b1;
                end else if (cr < -cth) begin
                    n_out.bit_value = 1'b0;
                end else if (cx > cth) begin
                    n_out.bit_value = 1'b1;
                end else if (-cx > cth) begin
                    n_out.bit_value = 1'b0;
                end else begin
                    n_out.end_of_stream = 1'b1;
                    n_ended             = 1'b1;
                end
                if (!n_out.end_of_stream) begin
                    n_level = n_center;
                    n_bits  = n_bits + INDEX_W'(1);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended   <= 1'b1;
            r_preload <= '0;
            r_skip    <= '0;
            r_fill    <= '0;
            r_early   <= '0;
            r_center  <= '0;
            r_slip    <= '0;
            r_level   <= '0;
            r_bits    <= '0;
        end else begin
            r_ended   <= n_ended;
            r_preload <= n_preload;
            r_skip    <= n_skip;
            r_fill    <= n_fill;
            r_early   <= n_early;
            r_center  <= n_center;
            r_slip    <= n_slip;
            r_level   <= n_level;
            r_bits    <= n_bits;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fire) begin
            r_out <= n_out;
        end
    end

endmodule
